/* design/ffb_pkg.sv */
// Package: shared constants, codes and sine table helpers for the torque generator.
`timescale 1ns / 1ps
package ffb_pkg;

  // Default sine table size (log2 of entries) and output limit.
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int TORQUE_LIMIT        = 5000;

  // Width of an unsaturated torque value and of the ramp quotient.
  localparam int RAW_W = 26;
  localparam int QW    = 11;

  // floor(2^32 / 1000), used for divide-by-1000 with one correction step.
  localparam logic [22:0] RECIP_1000 = 23'd4294967;

  // Effect kinds.
  localparam logic [2:0] EK_NONE     = 3'd0;
  localparam logic [2:0] EK_CONSTANT = 3'd1;
  localparam logic [2:0] EK_SPRING   = 3'd2;
  localparam logic [2:0] EK_DAMPER   = 3'd3;
  localparam logic [2:0] EK_INERTIA  = 3'd4;
  localparam logic [2:0] EK_FRICTION = 3'd5;
  localparam logic [2:0] EK_PERIODIC = 3'd6;
  localparam logic [2:0] EK_RAMP     = 3'd7;

  // Waveform codes.
  localparam logic [7:0] WF_SQUARE   = 8'd0;
  localparam logic [7:0] WF_SINE     = 8'd1;
  localparam logic [7:0] WF_TRIANGLE = 8'd2;
  localparam logic [7:0] WF_SAW_UP   = 8'd3;
  localparam logic [7:0] WF_SAW_DOWN = 8'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_EFFECT_KIND   = 3'd0;
  localparam logic [2:0] CFG_MAGNITUDE     = 3'd1;
  localparam logic [2:0] CFG_COEFFICIENT   = 3'd2;
  localparam logic [2:0] CFG_WAVEFORM      = 3'd3;
  localparam logic [2:0] CFG_TIMING_WORD   = 3'd4;
  localparam logic [2:0] CFG_RAMP_DURATION = 3'd5;
  localparam logic [2:0] CFG_END_MAGNITUDE = 3'd6;

  // sin(pi/2 * u/65536) in Q15 by a degree-9 Taylor series in Q30.
  function automatic logic [15:0] quarter_sine(longint unsigned u);
    longint unsigned one;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    one = 64'd1 << 30;
    x   = (u * 64'd1686629713) >> 16;
    x2  = (x * x) >> 30;
    t   = one - x2 / 72;
    t   = one - ((x2 * t) >> 30) / 42;
    t   = one - ((x2 * t) >> 30) / 20;
    t   = one - ((x2 * t) >> 30) / 6;
    s   = (x * t) >> 30;
    s   = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return 16'(s);
  endfunction

  // Full-wave table entry i of a table with 2^bits entries.
  function automatic logic signed [15:0] sine_entry(int unsigned i, int unsigned bits);
    int unsigned qbits;
    int unsigned qsize;
    int unsigned q;
    int unsigned r;
    longint unsigned u;
    logic signed [15:0] v;
    qbits = bits - 2;
    qsize = 1 << qbits;
    q     = (i >> qbits) & 3;
    r     = i & (qsize - 1);
    u     = ((q & 1) != 0) ? longint'(qsize - r) : longint'(r);
    v     = signed'(quarter_sine(u << (18 - bits)));
    return ((q & 2) != 0) ? -v : v;
  endfunction

  // Round v / 2^15 to nearest, ties away from zero (|v| below 2^25).
  function automatic logic signed [RAW_W-1:0] rnd_q15(logic signed [25:0] v);
    logic [25:0] a;
    logic [10:0] m;
    logic signed [RAW_W-1:0] r;
    a = v[25] ? 26'(-v) : 26'(v);
    m = 11'((a + 26'd16384) >> 15);
    r = RAW_W'(m);
    return v[25] ? -r : r;
  endfunction

endpackage

/* design/force_feedback_torque_generator_unit.sv */
// Top level: pipelined force feedback torque generator with a write-only register port.
// Throughput: one item per cycle while the output is not stalled; the ramp divider (one
// quotient bit per stage, 11 stages) sets the pipeline depth.
// A stalled output holds the whole pipeline; new items are taken whenever the output
// register is empty or being drained. Synchronous active-low reset clears the configuration registers and valids.
`timescale 1ns / 1ps
module force_feedback_torque_generator_unit #(
  parameter int SINE_TABLE_BITS = ffb_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // now_ms[31:0], wheel_position[63:32], wheel_velocity[95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // torque[13:0], was_clamped[14], zero[15]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int ROM_N  = 1 << SINE_TABLE_BITS;
  localparam int NSTG   = 17;
  localparam int RW     = ffb_pkg::RAW_W;
  localparam int QW     = ffb_pkg::QW;
  localparam int NRW    = 58;
  localparam int MISC_D = 13;
  localparam int PER_D  = 4;

  typedef logic signed [15:0] rom_t [ROM_N];

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < ROM_N; i++) begin
      t[i] = ffb_pkg::sine_entry(i, SINE_TABLE_BITS);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Configuration registers.
  logic [2:0]         kind_r;
  logic signed [15:0] mag_r;
  logic signed [15:0] coef_r;
  logic [7:0]         wave_r;
  logic [31:0]        tw_r;
  logic [31:0]        dur_r;
  logic signed [15:0] endm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= ffb_pkg::EK_NONE;
      mag_r  <= '0;
      coef_r <= '0;
      wave_r <= '0;
      tw_r   <= '0;
      dur_r  <= '0;
      endm_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ffb_pkg::CFG_EFFECT_KIND:   kind_r <= cfg_wdata[2:0];
        ffb_pkg::CFG_MAGNITUDE:     mag_r  <= cfg_wdata[15:0];
        ffb_pkg::CFG_COEFFICIENT:   coef_r <= cfg_wdata[15:0];
        ffb_pkg::CFG_WAVEFORM:      wave_r <= cfg_wdata[7:0];
        ffb_pkg::CFG_TIMING_WORD:   tw_r   <= cfg_wdata;
        ffb_pkg::CFG_RAMP_DURATION: dur_r  <= cfg_wdata;
        ffb_pkg::CFG_END_MAGNITUDE: endm_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Values derived from configuration only.
  logic signed [15:0] str_c;
  logic               dur_zero_c;
  logic [NRW-1:0]     dden_c;
  assign str_c      = (coef_r > 16'sd0) ? coef_r : mag_r;
  assign dur_zero_c = (dur_r == 32'd0);
  assign dden_c     = NRW'({dur_r, 15'b0});

  // Global pipeline advance: the output register is empty or being taken.
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Valid bits, one per stage.
  logic [NSTG-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[NSTG-2:0], in_tvalid};
      out_valid_r <= v_r[NSTG-1];
    end
  end

  // Input fields.
  logic [31:0]        now_c;
  logic signed [31:0] pos_c;
  logic signed [31:0] vel_c;
  assign now_c = in_tdata[31:0];
  assign pos_c = in_tdata[63:32];
  assign vel_c = in_tdata[95:64];

  // ---------------- Stage 1 ----------------
  localparam logic [54:0] RECIP_EXT = 55'(ffb_pkg::RECIP_1000);

  logic signed [31:0] op_c;
  logic signed [47:0] mp1_c;
  logic [54:0]        p0_c;
  assign op_c  = (kind_r == ffb_pkg::EK_SPRING) ? pos_c : vel_c;
  assign mp1_c = op_c * str_c;
  assign p0_c  = now_c * RECIP_EXT;

  logic signed [47:0] mp1_r;
  logic               fpos1_r, fneg1_r;
  logic [22:0]        q0_1_r;
  logic [31:0]        now1_r;
  logic [31:0]        diff1_r;
  logic               ge1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mp1_r   <= mp1_c;
      fpos1_r <= (vel_c >= 32'sd656);
      fneg1_r <= (vel_c <= -32'sd656);
      q0_1_r  <= p0_c[54:32];
      now1_r  <= now_c;
      diff1_r <= now_c - tw_r;
      ge1_r   <= (now_c >= tw_r);
    end
  end

  // ---------------- Stage 2 ----------------
  logic signed [9:0]  kmul_c;
  logic signed [56:0] mp2_c;
  logic [32:0]        t1_c;
  logic [10:0]        t1s_c;
  always_comb begin
    unique case (kind_r)
      ffb_pkg::EK_SPRING:  kmul_c = 10'sd400;
      ffb_pkg::EK_DAMPER:  kmul_c = 10'sd200;
      default:             kmul_c = 10'sd150;
    endcase
  end
  assign mp2_c = mp1_r * kmul_c;
  assign t1_c  = {1'b0, now1_r} - (33'(q0_1_r) * 33'd1000);
  assign t1s_c = t1_c[10:0];

  logic signed [56:0] mp2_r;
  logic               fpos2_r, fneg2_r;
  logic [9:0]         r1_2_r;
  logic [31:0]        el2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mp2_r   <= mp2_c;
      fpos2_r <= fpos1_r;
      fneg2_r <= fneg1_r;
      r1_2_r  <= (t1s_c >= 11'd1000) ? 10'(t1s_c - 11'd1000) : t1s_c[9:0];
      if (!ge1_r) begin
        el2_r <= '0;
      end else begin
        el2_r <= (diff1_r > dur_r) ? dur_r : diff1_r;
      end
    end
  end

  // ---------------- Stage 3 ----------------
  logic signed [16:0] dm_c;
  logic signed [32:0] el_s_c;
  logic signed [32:0] dur_s_c;
  logic signed [49:0] a3_c;
  logic signed [49:0] b3_c;
  assign dm_c    = 17'(endm_r) - 17'(mag_r);
  assign el_s_c  = {1'b0, el2_r};
  assign dur_s_c = {1'b0, dur_r};
  assign a3_c    = mag_r * dur_s_c;
  assign b3_c    = dm_c * el_s_c;

  logic [56:0]        ap3_r;
  logic               mn3_r;
  logic               fpos3_r, fneg3_r;
  logic [17:0]        y3_r;
  logic signed [49:0] a3_r, b3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ap3_r   <= mp2_r[56] ? 57'(-mp2_r) : 57'(mp2_r);
      mn3_r   <= mp2_r[56];
      fpos3_r <= fpos2_r;
      fneg3_r <= fneg2_r;
      y3_r    <= tw_r[23:16] * r1_2_r;
      a3_r    <= a3_c;
      b3_r    <= b3_c;
    end
  end

  // ---------------- Stage 4 ----------------
  logic [56:0]            sr_c;
  logic signed [RW-1:0]   spm_c;
  logic signed [RW-1:0]   sp_raw_c;
  logic signed [25:0]     cm_c;
  logic signed [25:0]     fm_c;
  logic signed [RW-1:0]   cst_c;
  logic signed [RW-1:0]   fr_c;
  logic signed [RW-1:0]   misc_c;
  logic [40:0]            p1_c;
  assign sr_c     = ap3_r + (57'd1 << 30);
  assign spm_c    = sr_c[56:31];
  assign sp_raw_c = mn3_r ? spm_c : -spm_c;
  assign cm_c     = mag_r * 11'sd1000;
  assign fm_c     = str_c * 10'sd400;
  assign cst_c    = ffb_pkg::rnd_q15(cm_c);
  assign fr_c     = ffb_pkg::rnd_q15(fm_c);
  assign p1_c     = y3_r * 41'(ffb_pkg::RECIP_1000);

  // Effect select for everything but periodic and a running ramp.
  always_comb begin
    unique case (kind_r)
      ffb_pkg::EK_CONSTANT: misc_c = cst_c;
      ffb_pkg::EK_RAMP:     misc_c = cst_c;
      ffb_pkg::EK_SPRING,
      ffb_pkg::EK_DAMPER,
      ffb_pkg::EK_INERTIA:  misc_c = sp_raw_c;
      ffb_pkg::EK_FRICTION: begin
        if (fpos3_r) begin
          misc_c = -fr_c;
        end else if (fneg3_r) begin
          misc_c = fr_c;
        end else begin
          misc_c = '0;
        end
      end
      default:              misc_c = '0;
    endcase
  end

  logic signed [RW-1:0] misc4_r;
  logic [8:0]           q1_4_r;
  logic [17:0]          y4_r;
  logic signed [49:0]   x4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      misc4_r <= misc_c;
      q1_4_r  <= p1_c[40:32];
      y4_r    <= y3_r;
      x4_r    <= a3_r + b3_r;
    end
  end

  // ---------------- Stage 5 ----------------
  logic [17:0] t2_c;
  assign t2_c = y4_r - (18'(q1_4_r) * 18'd1000);

  logic [9:0]  r2_5_r;
  logic [47:0] ax5_r;
  logic        neg5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_5_r <= (t2_c[10:0] >= 11'd1000) ? 10'(t2_c[10:0] - 11'd1000) : t2_c[9:0];
      ax5_r  <= x4_r[49] ? 48'(-x4_r) : 48'(x4_r);
      neg5_r <= x4_r[49];
    end
  end

  // ---------------- Stage 6 ----------------
  logic [25:0] x6_c;
  logic [48:0] p2_c;
  assign x6_c = {r2_5_r, 16'b0};
  assign p2_c = x6_c * 49'(ffb_pkg::RECIP_1000);

  logic [16:0]    q2_6_r;
  logic [25:0]    x6_r;
  logic [NRW-1:0] n6_r;
  logic           neg6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q2_6_r <= p2_c[48:32];
      x6_r   <= x6_c;
      n6_r   <= (NRW'(ax5_r) * NRW'(1000)) + NRW'({dur_r, 14'b0});
      neg6_r <= neg5_r;
    end
  end

  // ---------------- Periodic stages 7 to 13 ----------------
  logic [25:0] t3_c;
  assign t3_c = x6_r - (26'(q2_6_r) * 26'd1000);

  logic [15:0]        frac7_r;
  logic [15:0]        theta8_r;
  logic [15:0]        theta9_r;
  logic signed [15:0] tab9_r;
  logic signed [16:0] w10_r;
  logic signed [33:0] pm11_r;
  logic signed [43:0] p12_r;
  logic signed [RW-1:0] per13_r;

  logic signed [17:0] th_s_c;
  logic signed [17:0] tri_c;
  logic signed [16:0] w_c;
  always_comb begin
    th_s_c = {2'b0, theta9_r};
    tri_c  = theta9_r[15] ? (18'sd98304 - (th_s_c <<< 1)) : ((th_s_c <<< 1) - 18'sd32768);
    unique case (wave_r)
      ffb_pkg::WF_SQUARE:   w_c = tab9_r[15] ? -17'sd32768 : 17'sd32768;
      ffb_pkg::WF_TRIANGLE: w_c = tri_c[16:0];
      ffb_pkg::WF_SAW_UP:   w_c = 17'(th_s_c - 18'sd32768);
      ffb_pkg::WF_SAW_DOWN: w_c = 17'(18'sd32768 - th_s_c);
      default:              w_c = 17'(tab9_r);
    endcase
  end

  logic signed [8:0]  off_c;
  logic signed [33:0] offs_c;
  logic signed [33:0] wm_c;
  logic signed [43:0] pmul_c;
  logic [43:0]        pa_c;
  logic [43:0]        pr_c;
  logic signed [RW-1:0] pmag_c;
  assign off_c  = $signed({1'b0, tw_r[7:0]}) - 9'sd128;
  assign offs_c = 34'(off_c) <<< 23;
  assign wm_c   = w10_r * mag_r;
  assign pmul_c = pm11_r * 11'sd800;
  assign pa_c   = p12_r[43] ? 44'(-p12_r) : 44'(p12_r);
  assign pr_c   = pa_c + (44'd1 << 29);
  assign pmag_c = RW'(pr_c[43:30]);

  always_ff @(posedge clk) begin
    if (en) begin
      frac7_r  <= q2_6_r[15:0] + 16'((t3_c >= 26'd1000) ? 1 : 0);
      theta8_r <= frac7_r + {tw_r[15:8], 8'b0};
      theta9_r <= theta8_r;
      tab9_r   <= SINE_ROM[theta8_r[15 -: SINE_TABLE_BITS]];
      w10_r    <= w_c;
      pm11_r   <= wm_c + offs_c;
      p12_r    <= pmul_c;
      per13_r  <= p12_r[43] ? -pmag_c : pmag_c;
    end
  end

  // ---------------- Ramp divider, stages 7 to 17 ----------------
  logic [NRW-1:0] drem_r [QW];
  logic [QW-1:0]  dq_r   [QW];
  logic           dneg_r [QW];
  logic [NRW-1:0] drem_nxt [QW];
  logic [QW-1:0]  dq_nxt   [QW];

  // Restoring division, one quotient bit per stage, most significant first.
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      logic [NRW-1:0] din;
      logic [NRW-1:0] dsh;
      logic [QW-1:0]  qin;
      din = (j == 0) ? n6_r : drem_r[(j == 0) ? 0 : j - 1];
      qin = (j == 0) ? '0 : dq_r[(j == 0) ? 0 : j - 1];
      dsh = dden_c << (QW - 1 - j);
      if (din >= dsh) begin
        drem_nxt[j] = din - dsh;
        dq_nxt[j]   = qin | (QW'(1) << (QW - 1 - j));
      end else begin
        drem_nxt[j] = din;
        dq_nxt[j]   = qin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        drem_r[j] <= drem_nxt[j];
        dq_r[j]   <= dq_nxt[j];
        dneg_r[j] <= (j == 0) ? neg6_r : dneg_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // ---------------- Alignment delays ----------------
  logic signed [RW-1:0] misc_dly_r [MISC_D];
  logic signed [RW-1:0] per_dly_r  [PER_D];

  always_ff @(posedge clk) begin
    if (en) begin
      misc_dly_r[0] <= misc4_r;
      for (int i = 1; i < MISC_D; i++) begin
        misc_dly_r[i] <= misc_dly_r[i - 1];
      end
      per_dly_r[0] <= per13_r;
      for (int i = 1; i < PER_D; i++) begin
        per_dly_r[i] <= per_dly_r[i - 1];
      end
    end
  end

  // ---------------- Output stage: select and saturate ----------------
  logic signed [RW-1:0] ramp_c;
  logic signed [RW-1:0] raw_c;
  logic signed [RW-1:0] sat_c;
  logic                 clamp_c;
  localparam logic signed [RW-1:0] LIM = RW'(ffb_pkg::TORQUE_LIMIT);

  assign ramp_c = dneg_r[QW-1] ? -RW'(dq_r[QW-1]) : RW'(dq_r[QW-1]);

  always_comb begin
    if (kind_r == ffb_pkg::EK_PERIODIC) begin
      raw_c = per_dly_r[PER_D-1];
    end else if ((kind_r == ffb_pkg::EK_RAMP) && !dur_zero_c) begin
      raw_c = ramp_c;
    end else begin
      raw_c = misc_dly_r[MISC_D-1];
    end
    priority if (raw_c > LIM) begin
      sat_c   = LIM;
      clamp_c = 1'b1;
    end else if (raw_c < -LIM) begin
      sat_c   = -LIM;
      clamp_c = 1'b1;
    end else begin
      sat_c   = raw_c;
      clamp_c = 1'b0;
    end
  end

  logic [15:0] out_data_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {1'b0, clamp_c, sat_c[13:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/ffb_checker.sv */
// Checker: port-level properties of the torque generator, bound to the top level.
`timescale 1ns / 1ps
module ffb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  localparam int LIM = ffb_pkg::TORQUE_LIMIT;
  localparam logic [13:0] LIM_P = 14'(LIM);
  localparam logic [13:0] LIM_N = 14'(-LIM);

  // A stalled result item keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // The pipeline takes input exactly when the output register can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // A clamped result sits exactly on the limit.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[14] |-> (out_tdata[13:0] == LIM_P) || (out_tdata[13:0] == LIM_N))
    else $error("clamp flag without torque at limit");

  // Results stay inside the limit and the pad bit is zero.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[15] && ((LIM > 8191) ||
      (($signed(out_tdata[13:0]) <= 14'sd0 + $signed(LIM_P)) &&
       ($signed(out_tdata[13:0]) >= $signed(LIM_N)))))
    else $error("torque outside limit");

endmodule

bind force_feedback_torque_generator_unit ffb_checker u_ffb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/tb_top.sv */
// Self-checking testbench for the force feedback torque generator.
`timescale 1ns / 1ps
module tb_top;

  localparam int TAB_BITS   = ffb_pkg::SINE_TABLE_BITS_DEF;
  localparam int CYCLE_CAP  = 600000;
  localparam int PIPE_DELAY = 18;

  typedef struct packed {
    logic [13:0] torque;
    logic        clamp;
  } torque_t;

  // One directed row: full register set, one item, and an optional typed result.
  typedef struct {
    logic [2:0]         kind;
    logic signed [15:0] mag;
    logic signed [15:0] coef;
    logic [7:0]         wave;
    logic [31:0]        timing;
    logic [31:0]        dur;
    logic signed [15:0] endm;
    logic [31:0]        now;
    logic [31:0]        pos;
    logic [31:0]        vel;
    bit                 typed;
    int                 torque;
    bit                 clamp;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  // Local copy of the register file.
  logic [2:0]         fx_kind;
  logic signed [15:0] fx_mag;
  logic signed [15:0] fx_coef;
  logic [7:0]         fx_wave;
  logic [31:0]        fx_timing;
  logic [31:0]        fx_dur;
  logic signed [15:0] fx_endm;

  int      sine_tab [0:(1 << TAB_BITS) - 1];
  torque_t torque_q [$];
  bit      typed_on;
  torque_t typed_val;
  bit      idle_on;
  int      errors;
  int      n_items;
  int      n_results;
  int      n_clamped;
  int      cycles;
  row_t    rows [$];

  force_feedback_torque_generator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Rounded division, ties away from zero.
  function automatic longint rdiv(longint num, longint den);
    longint a;
    longint q;
    a = (num < 0) ? -num : num;
    q = (a + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Quarter-wave sine in Q15 from a Taylor series in Q30, u in 0..65536.
  function automatic int qsine(longint unsigned u);
    longint unsigned unity;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned sv;
    unity = 64'd1 << 30;
    x  = (u * 64'd1686629713) >> 16;
    x2 = (x * x) >> 30;
    t  = unity - x2 / 72;
    t  = unity - ((x2 * t) >> 30) / 42;
    t  = unity - ((x2 * t) >> 30) / 20;
    t  = unity - ((x2 * t) >> 30) / 6;
    sv = (x * t) >> 30;
    sv = (sv + (64'd1 << 14)) >> 15;
    if (sv > 32767) begin
      sv = 32767;
    end
    return int'(sv);
  endfunction

  // Expected torque for one item under the current register copy.
  function automatic torque_t predict_torque(logic [31:0] now, logic signed [31:0] pos,
                                             logic signed [31:0] vel);
    longint m;
    longint s;
    longint p;
    longint v;
    longint raw;
    longint f;
    longint w;
    longint off;
    longint e;
    longint d;
    longint el;
    longint nw;
    longint frac;
    longint theta;
    int     tab;
    torque_t r;
    m   = fx_mag;
    s   = (fx_coef > 0) ? longint'(fx_coef) : m;
    p   = pos;
    v   = vel;
    nw  = longint'({32'd0, now});
    raw = 0;
    case (fx_kind)
      ffb_pkg::EK_CONSTANT: raw = rdiv(m * 1000, 64'd1 << 15);
      ffb_pkg::EK_SPRING:   raw = rdiv(-(p * s * 400), 64'd1 << 31);
      ffb_pkg::EK_DAMPER:   raw = rdiv(-(v * s * 200), 64'd1 << 31);
      ffb_pkg::EK_INERTIA:  raw = rdiv(-(v * s * 150), 64'd1 << 31);
      ffb_pkg::EK_FRICTION: begin
        f = rdiv(s * 400, 64'd1 << 15);
        if (v >= 656) begin
          raw = -f;
        end else if (v <= -656) begin
          raw = f;
        end else begin
          raw = 0;
        end
      end
      ffb_pkg::EK_PERIODIC: begin
        off   = longint'(fx_timing[7:0]) - 128;
        frac  = ((longint'(fx_timing[23:16]) * nw) % 1000) * 65536 / 1000;
        theta = (frac + longint'(fx_timing[15:8]) * 256) & 64'hFFFF;
        tab   = sine_tab[theta >> (16 - TAB_BITS)];
        case (fx_wave)
          ffb_pkg::WF_SQUARE:   w = (tab >= 0) ? 32768 : -32768;
          ffb_pkg::WF_TRIANGLE: w = (theta < 32768) ? theta * 2 - 32768 : 98304 - theta * 2;
          ffb_pkg::WF_SAW_UP:   w = theta - 32768;
          ffb_pkg::WF_SAW_DOWN: w = 32768 - theta;
          default:              w = tab;
        endcase
        raw = rdiv((w * m + off * (64'd1 << 23)) * 800, 64'd1 << 30);
      end
      ffb_pkg::EK_RAMP: begin
        if (fx_dur == 0) begin
          raw = rdiv(m * 1000, 64'd1 << 15);
        end else begin
          e  = fx_endm;
          d  = longint'({32'd0, fx_dur});
          el = (now >= fx_timing) ? nw - longint'({32'd0, fx_timing}) : 0;
          if (el > d) begin
            el = d;
          end
          raw = rdiv((m * d + (e - m) * el) * 1000, d << 15);
        end
      end
      default: raw = 0;
    endcase
    r.clamp = 1'b0;
    if (raw > ffb_pkg::TORQUE_LIMIT) begin
      raw = ffb_pkg::TORQUE_LIMIT;
      r.clamp = 1'b1;
    end else if (raw < -ffb_pkg::TORQUE_LIMIT) begin
      raw = -ffb_pkg::TORQUE_LIMIT;
      r.clamp = 1'b1;
    end
    r.torque = raw[13:0];
    return r;
  endfunction

  // Record expectations on accepted items and check accepted results.
  always @(posedge clk) begin
    torque_t got;
    torque_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (typed_on) begin
          torque_q.push_back(typed_val);
        end else begin
          torque_q.push_back(predict_torque(in_tdata[31:0], in_tdata[63:32],
                                            in_tdata[95:64]));
        end
        n_items++;
      end
      if (out_tvalid && out_tready) begin
        got.torque = out_tdata[13:0];
        got.clamp  = out_tdata[14];
        n_results++;
        if (got.clamp) begin
          n_clamped++;
        end
        if (torque_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result torque=%0d clamp=%0b", $time,
                   $signed(got.torque), got.clamp);
        end else begin
          want = torque_q.pop_front();
          if (got.torque !== want.torque) begin
            errors++;
            $display("%0t: torque mismatch expected %0d actual %0d", $time,
                     $signed(want.torque), $signed(got.torque));
          end
          if (got.clamp !== want.clamp) begin
            errors++;
            $display("%0t: clamp flag mismatch expected %0b actual %0b", $time,
                     want.clamp, got.clamp);
          end
        end
      end
    end
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("force_feedback_torque_generator_unit test failed");
      $finish;
    end
  end

  // Result side: ready in random bursts, stalls only while idling is enabled.
  initial begin
    int k;
    @(posedge rst_n);
    forever begin
      k = $urandom_range(1, 30);
      repeat (k) @(negedge clk);
      if (idle_on && $urandom_range(0, 1)) begin
        out_tready = 1'b0;
        k = $urandom_range(1, 19);
        repeat (k) @(negedge clk);
        out_tready = 1'b1;
      end
    end
  end

  // Register write on the falling edge; the copy follows at once since the block is idle.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    case (idx)
      ffb_pkg::CFG_EFFECT_KIND:   fx_kind   = val[2:0];
      ffb_pkg::CFG_MAGNITUDE:     fx_mag    = val[15:0];
      ffb_pkg::CFG_COEFFICIENT:   fx_coef   = val[15:0];
      ffb_pkg::CFG_WAVEFORM:      fx_wave   = val[7:0];
      ffb_pkg::CFG_TIMING_WORD:   fx_timing = val;
      ffb_pkg::CFG_RAMP_DURATION: fx_dur    = val;
      ffb_pkg::CFG_END_MAGNITUDE: fx_endm   = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Wait for every expected result, let the pipe settle, then load all registers.
  task automatic load_effect(logic [2:0] kind, logic [15:0] mag, logic [15:0] coef,
                             logic [7:0] wave, logic [31:0] timing, logic [31:0] dur,
                             logic [15:0] endm);
    while (torque_q.size() != 0) @(posedge clk);
    repeat (PIPE_DELAY + 4) @(posedge clk);
    write_reg(ffb_pkg::CFG_EFFECT_KIND, {29'd0, kind});
    write_reg(ffb_pkg::CFG_MAGNITUDE, {16'd0, mag});
    write_reg(ffb_pkg::CFG_COEFFICIENT, {16'd0, coef});
    write_reg(ffb_pkg::CFG_WAVEFORM, {24'd0, wave});
    write_reg(ffb_pkg::CFG_TIMING_WORD, timing);
    write_reg(ffb_pkg::CFG_RAMP_DURATION, dur);
    write_reg(ffb_pkg::CFG_END_MAGNITUDE, {16'd0, endm});
  endtask

  // Present one item, hold it until taken, then maybe leave a gap.
  task automatic send_item(logic [31:0] now, logic [31:0] pos, logic [31:0] vel);
    int k;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {vel, pos, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      k = $urandom_range(1, 19);
      repeat (k - 1) @(negedge clk);
    end
  endtask

  // Signed Q16.16 value: mostly moderate, sometimes full range or near zero.
  function automatic logic [31:0] pick_motion();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 1200)) - 1200);
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic row_t mk(logic [2:0] kind, logic [15:0] mag, logic [15:0] coef,
                              logic [7:0] wave, logic [31:0] timing, logic [31:0] dur,
                              logic [15:0] endm, logic [31:0] now, logic [31:0] pos,
                              logic [31:0] vel, bit typed, int torque, bit clamp);
    row_t r;
    r.kind = kind; r.mag = mag; r.coef = coef; r.wave = wave; r.timing = timing;
    r.dur = dur; r.endm = endm; r.now = now; r.pos = pos; r.vel = vel;
    r.typed = typed; r.torque = torque; r.clamp = clamp;
    return r;
  endfunction

  initial begin
    logic [2:0]  kind;
    logic [31:0] timing;
    logic [31:0] dur;
    logic [31:0] now;
    logic [31:0] vel;
    int          n_cfg;
    int          guard;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b1;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    typed_on   = 1'b0;
    typed_val  = '0;
    idle_on    = 1'b1;
    errors     = 0;
    n_items    = 0;
    n_results  = 0;
    n_clamped  = 0;
    cycles     = 0;
    n_cfg      = 0;
    fx_kind = '0; fx_mag = '0; fx_coef = '0; fx_wave = '0;
    fx_timing = '0; fx_dur = '0; fx_endm = '0;

    // Full sine table, mirrored from the quarter wave.
    for (int i = 0; i < (1 << TAB_BITS); i++) begin
      int q;
      int rr;
      int uu;
      int vv;
      q  = (i >> (TAB_BITS - 2)) & 3;
      rr = i & ((1 << (TAB_BITS - 2)) - 1);
      uu = (q & 1) ? ((1 << (TAB_BITS - 2)) - rr) : rr;
      vv = qsine(longint'(uu) << (18 - TAB_BITS));
      sine_tab[i] = (q & 2) ? -vv : vv;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: reset values, extremes, every effect and waveform, special cases.
    rows.push_back(mk(ffb_pkg::EK_NONE, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, 32'hFFFFFFFF,
                      32'h7FFFFFFF, 32'h80000000, 1, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_CONSTANT, 16'h7FFF, 0, 0, 0, 0, 0, 0, 0, 0,
                      1, 1000, 0));
    rows.push_back(mk(ffb_pkg::EK_CONSTANT, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 0,
                      1, -1000, 0));
    rows.push_back(mk(ffb_pkg::EK_SPRING, 0, 16'h7FFF, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 0,
                      1, -5000, 1));
    rows.push_back(mk(ffb_pkg::EK_SPRING, 0, 16'h7FFF, 0, 0, 0, 0, 0, 32'h80000000, 0,
                      1, 5000, 1));
    rows.push_back(mk(ffb_pkg::EK_SPRING, 16'h4000, 16'h8000, 0, 0, 0, 0, 0, 32'h00012345,
                      0, 0, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_DAMPER, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF,
                      0, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_INERTIA, 0, 16'h7FFF, 0, 0, 0, 0, 0, 0, 32'hFFFF0000,
                      0, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_FRICTION, 0, 16'h7FFF, 0, 0, 0, 0, 0, 0, 32'd656,
                      1, -400, 0));
    rows.push_back(mk(ffb_pkg::EK_FRICTION, 0, 16'h7FFF, 0, 0, 0, 0, 0, 0, 32'd655,
                      1, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_FRICTION, 0, 16'h7FFF, 0, 0, 0, 0, 0, 0, -32'sd656,
                      1, 400, 0));
    rows.push_back(mk(ffb_pkg::EK_PERIODIC, 16'h7FFF, 0, ffb_pkg::WF_SQUARE, 32'h00FF00FF,
                      0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_PERIODIC, 16'h8000, 0, ffb_pkg::WF_SINE, 32'h00014080,
                      0, 0, 250, 0, 0, 0, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_PERIODIC, 16'h7FFF, 0, ffb_pkg::WF_TRIANGLE, 32'h000A0000,
                      0, 0, 37, 0, 0, 0, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_PERIODIC, 16'h7FFF, 0, ffb_pkg::WF_SAW_UP, 32'h00030000,
                      0, 0, 77, 0, 0, 0, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_PERIODIC, 16'h7FFF, 0, ffb_pkg::WF_SAW_DOWN, 32'h00030000,
                      0, 0, 77, 0, 0, 0, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_PERIODIC, 16'h4000, 0, 8'hFF, 32'h00050000, 0, 0, 33,
                      0, 0, 0, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_RAMP, 16'h4000, 0, 0, 100, 0, 16'h8000, 500, 0, 0,
                      1, 500, 0));
    rows.push_back(mk(ffb_pkg::EK_RAMP, 16'h4000, 0, 0, 1000, 200, 16'h8000, 5, 0, 0,
                      1, 500, 0));
    rows.push_back(mk(ffb_pkg::EK_RAMP, 16'h4000, 0, 0, 1000, 200, 16'h8000, 1100, 0, 0,
                      0, 0, 0));
    rows.push_back(mk(ffb_pkg::EK_RAMP, 16'h4000, 0, 0, 1000, 200, 16'h8000, 5000, 0, 0,
                      1, -1000, 0));
    rows.push_back(mk(ffb_pkg::EK_RAMP, 16'h7FFF, 0, 0, 0, 32'hFFFFFFFF, 16'h8000,
                      32'hFFFFFFFF, 0, 0, 0, 0, 0));
    foreach (rows[i]) begin
      load_effect(rows[i].kind, rows[i].mag, rows[i].coef, rows[i].wave,
                  rows[i].timing, rows[i].dur, rows[i].endm);
      n_cfg++;
      typed_on         = rows[i].typed;
      typed_val.torque = 14'(rows[i].torque);
      typed_val.clamp  = rows[i].clamp;
      send_item(rows[i].now, rows[i].pos, rows[i].vel);
      @(negedge clk);
      in_tvalid = 1'b0;
      typed_on  = 1'b0;
    end

    // Random phases, one register setting each; the last phase runs without idling.
    for (int ph = 0; ph < 9; ph++) begin
      kind   = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      timing = $urandom();
      dur    = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : 32'($urandom_range(0, 3000));
      if (ph == 7) begin
        dur = 32'hFFFFFFFF;
      end
      load_effect(kind, pick_level(), pick_level(), 8'($urandom_range(0, 6)), timing, dur,
                  pick_level());
      n_cfg++;
      idle_on = (ph < 8);
      for (int k = 0; k < 180; k++) begin
        now = $urandom();
        vel = pick_motion();
        if (kind == ffb_pkg::EK_RAMP && $urandom_range(0, 3) != 0) begin
          now = timing + 32'($urandom_range(0, 3200)) - 32'd100;
        end
        if (kind == ffb_pkg::EK_FRICTION && $urandom_range(0, 1)) begin
          vel = 32'($signed($urandom_range(0, 8)) + ($urandom_range(0, 1) ? 652 : -660));
        end
        send_item(now, pick_motion(), vel);
      end
      @(negedge clk);
      in_tvalid = 1'b0;
    end

    // Drain and let the pipeline settle.
    guard = 0;
    while (torque_q.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_DELAY + 10) @(posedge clk);

    $display("Covered %0d items over %0d register settings; %0d results, %0d saturated.",
             n_items, n_cfg, n_results, n_clamped);
    if (errors == 0 && torque_q.size() == 0) begin
      $display("force_feedback_torque_generator_unit test passed");
    end else begin
      $display("%0d mismatches, %0d results still missing", errors, torque_q.size());
      $display("force_feedback_torque_generator_unit test failed");
    end
    $finish;
  end

endmodule
